// File: hw/rtl/merkle_path_verifier_top_defines.svh
// Assertion macros for the Merkle path verifier.
`ifndef MERKLE_PATH_VERIFIER_TOP_DEFINES_SVH
`define MERKLE_PATH_VERIFIER_TOP_DEFINES_SVH
// Assert that antecedent implies consequent on the next clock edge.
`define MPV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// Assert that a condition holds at every clock edge.
`define MPV_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

// File: hw/rtl/mpv_pkg.sv
// Package for the Merkle path verifier: types, constants and SHA-256 functions.
package mpv_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_DONE
   } state_type;

   localparam logic [1:0] SIDE_RUN_LEFT = 2'd0;
   localparam logic [1:0] SIDE_SIB_LEFT = 2'd1;
   localparam logic [1:0] LAST_WORD     = 2'd3;
   localparam logic [7:0] PREFIX_BYTE   = 8'h01;

   // Datapath commands from the controller
   typedef struct packed {
      logic init_hash;  // load initial hash words, block 0
      logic load_block; // load message schedule and working vars
      logic do_round;   // one compression round
      logic add_hash;   // fold working vars into hash words
      logic commit;     // hash words to running digest
   } cmd_type;

   typedef struct packed {
      logic last_round;
      logic last_block;
   } status_type;

   localparam logic [31:0] KTAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [255:0] HINIT = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: hw/rtl/mpv_ctrl.sv
// Controller state machine for the Merkle path verifier.
module mpv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 rsp_stall,
   input  logic                 need_rsp,
   input  mpv_pkg::status_type  status,
   output mpv_pkg::cmd_type     cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   mpv_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpv_pkg::ST_IDLE:  if (start) state_in = mpv_pkg::ST_LOAD;
         mpv_pkg::ST_LOAD:  state_in = mpv_pkg::ST_ROUND;
         mpv_pkg::ST_ROUND: if (status.last_round) state_in = mpv_pkg::ST_ADD;
         mpv_pkg::ST_ADD: begin
            if (!status.last_block) state_in = mpv_pkg::ST_LOAD;
            else if (need_rsp) state_in = mpv_pkg::ST_DONE;
            else state_in = mpv_pkg::ST_IDLE;
         end
         mpv_pkg::ST_DONE:  if (!rsp_stall) state_in = mpv_pkg::ST_IDLE;
         default:           state_in = mpv_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         mpv_pkg::ST_IDLE: begin
            busy          = 1'b0;
            cmd.init_hash = start;
         end
         mpv_pkg::ST_LOAD:  cmd.load_block = 1'b1;
         mpv_pkg::ST_ROUND: cmd.do_round = 1'b1;
         mpv_pkg::ST_ADD: begin
            cmd.add_hash = 1'b1;
            cmd.commit   = status.last_block;
         end
         mpv_pkg::ST_DONE:  rsp_valid = 1'b1;
         default:           busy = 1'b1;
      endcase
   end

endmodule

// File: hw/rtl/mpv_datapath.sv
// SHA-256 datapath with digest storage for the Merkle path verifier.
module mpv_datapath (
   input  logic                clock,
   input  logic                reset,
   input  mpv_pkg::cmd_type    cmd,
   input  logic                wr_en,
   input  logic [1:0]          wr_index,
   input  logic [63:0]         wr_word,
   input  logic [1:0]          wr_side,
   input  logic                load_leaf,
   output mpv_pkg::status_type status,
   output logic [1:0]          side_now,
   output logic [255:0]        digest
);

   logic [63:0]  sib_ff [4];
   logic [255:0] run_ff, run_in;
   logic [1:0]   side_ff;
   logic [255:0] hash_ff;
   logic [255:0] vars_ff;
   logic [511:0] sched_ff;
   logic [5:0]   round_ff;
   logic         block_ff;
   logic [255:0] sib_cat;
   logic [511:0] left_right;
   logic [1023:0] msg;
   logic [31:0]  a, b, c, d, e, f, g, h, w, t1, t2, s0, s1, wn, w2, w15;

   function automatic logic [255:0] run_in_hash(input logic [255:0] hv, input logic [255:0] vv);
      logic [255:0] r;
      for (int i = 0; i < 8; i++) r[32*i +: 32] = hv[32*i +: 32] + vv[32*i +: 32];
      run_in_hash = r;
   endfunction

   assign sib_cat    = {sib_ff[0], sib_ff[1], sib_ff[2], sib_ff[3]};
   assign left_right = (side_ff == mpv_pkg::SIDE_RUN_LEFT) ? {run_ff, sib_cat} :
                                                             {sib_cat, run_ff};
   // 0x01 || left || right || pad, length 520 bits
   assign msg = {mpv_pkg::PREFIX_BYTE, left_right, 8'h80, 480'd0, 16'h0208};

   assign side_now = (wr_en && wr_index == 2'd0) ? wr_side : side_ff;
   assign status.last_round = (round_ff == 6'd63);
   assign status.last_block = block_ff;
   assign digest = run_ff;

   // Sibling words and side code
   always_ff @(posedge clock) begin
      if (wr_en) sib_ff[wr_index] <= wr_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
         run_ff  <= '0;
      end else begin
         if (wr_en && wr_index == 2'd0) side_ff <= wr_side;
         run_ff <= run_in;
      end
   end

   // Running digest update: leaf load or hash commit
   always_comb begin
      run_in = run_ff;
      if (load_leaf) run_in = {sib_ff[0], sib_ff[1], sib_ff[2], wr_word};
      if (cmd.commit) begin
         run_in = {hash_ff[255:224] + vars_ff[255:224], hash_ff[223:192] + vars_ff[223:192],
                   hash_ff[191:160] + vars_ff[191:160], hash_ff[159:128] + vars_ff[159:128],
                   hash_ff[127:96] + vars_ff[127:96], hash_ff[95:64] + vars_ff[95:64],
                   hash_ff[63:32] + vars_ff[63:32], hash_ff[31:0] + vars_ff[31:0]};
      end
   end

   // Round logic
   always_comb begin
      {a, b, c, d, e, f, g, h} = vars_ff;
      w15 = sched_ff[479:448];
      w2  = sched_ff[63:32];
      s0  = mpv_pkg::rotr(w15, 7) ^ mpv_pkg::rotr(w15, 18) ^ (w15 >> 3);
      s1  = mpv_pkg::rotr(w2, 17) ^ mpv_pkg::rotr(w2, 19) ^ (w2 >> 10);
      wn  = s1 + sched_ff[223:192] + s0 + sched_ff[511:480];
      w   = sched_ff[511:480];
      t1  = h + (mpv_pkg::rotr(e, 6) ^ mpv_pkg::rotr(e, 11) ^ mpv_pkg::rotr(e, 25)) +
            ((e & f) ^ (~e & g)) + mpv_pkg::KTAB[round_ff] + w;
      t2  = (mpv_pkg::rotr(a, 2) ^ mpv_pkg::rotr(a, 13) ^ mpv_pkg::rotr(a, 22)) +
            ((a & b) ^ (a & c) ^ (b & c));
   end

   // Engine registers; schedule is a 16-word shift window, oldest at top
   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
         block_ff <= 1'b0;
      end else begin
         if (cmd.init_hash) begin
            block_ff <= 1'b0;
         end else if (cmd.add_hash) begin
            block_ff <= ~block_ff;
         end
         if (cmd.load_block) round_ff <= '0;
         else if (cmd.do_round) round_ff <= round_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_hash) hash_ff <= mpv_pkg::HINIT;
      if (cmd.load_block) begin
         sched_ff <= block_ff ? msg[511:0] : msg[1023:512];
         vars_ff  <= hash_ff;
      end
      if (cmd.do_round) begin
         vars_ff  <= {t1 + t2, a, b, c, d + t1, e, f, g};
         sched_ff <= {sched_ff[479:0], wn};
      end
      if (cmd.add_hash) hash_ff <= run_in_hash(hash_ff, vars_ff);
   end

endmodule

// File: hw/rtl/merkle_path_verifier_top.sv
// Top level of the Merkle path verifier.
// Usage:
//  - req_ channel: one 64-bit digest word per transaction with its index,
//    side code (taken with word 0) and first/last flags (taken with word 3).
//  - Words 0 to 2 are stored on acceptance. Word 3 of a leaf loads the
//    running digest at once; word 3 of a sibling starts a two-block SHA-256
//    of 0x01||left||right, each block a load, 64 rounds and an add in the
//    single round unit. Side codes 2 and 3 leave the digest as is.
//  - When last_node is set, one rsp_ transaction gives mismatch, valid in the
//    same cycle the digest is final. req_stall is high while hashing or
//    while the result waits.
//  - A stalled result holds until rsp_stall drops; no new word is taken.
//  - User must write root words 0..3 via csr_ only while idle; not enforced.
//  - Synchronous reset clears the controller, running digest and roots.
module merkle_path_verifier_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_digest_word,
   input  logic [1:0]  req_word_index,
   input  logic [1:0]  req_side,
   input  logic        req_first_node,
   input  logic        req_last_node,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_mismatch,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   `include "merkle_path_verifier_top_defines.svh"

   mpv_pkg::cmd_type    cmd;
   mpv_pkg::status_type status;
   logic         busy, accept, word3, start, leaf_done, need_rsp;
   logic         pend_ff, pend_in, lastflag_ff, dly_ff;
   logic [1:0]   side_now;
   logic [255:0] digest, root_ff;

   assign accept = req_valid && !req_stall;
   assign word3  = accept && req_word_index == mpv_pkg::LAST_WORD;
   assign start  = word3 && !req_first_node &&
                   (side_now == mpv_pkg::SIDE_RUN_LEFT || side_now == mpv_pkg::SIDE_SIB_LEFT);
   assign leaf_done = word3 && !start && req_last_node;
   assign need_rsp  = lastflag_ff;
   assign req_stall = busy || pend_ff;
   assign csr_ready = 1'b1;

   mpv_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .rsp_stall(rsp_stall),
      .need_rsp(need_rsp), .status(status), .cmd(cmd), .busy(busy),
      .rsp_valid(dly_ff)
   );

   mpv_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .wr_en(accept),
      .wr_index(req_word_index), .wr_word(req_digest_word), .wr_side(req_side),
      .load_leaf(word3 && req_first_node), .status(status), .side_now(side_now),
      .digest(digest)
   );

   // Root registers
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         root_ff[255 - 64*csr_index -: 64] <= csr_data;
      end
   end

   // Result for proofs that end without hashing
   always_comb begin
      pend_in = pend_ff;
      if (leaf_done) pend_in = 1'b1;
      else if (pend_ff && !rsp_stall) pend_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= 1'b0;
         lastflag_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (start) lastflag_ff <= req_last_node;
      end
   end

   assign rsp_valid    = pend_ff || dly_ff;
   assign rsp_mismatch = (digest != root_ff);

   `MPV_ASSERT_ALWAYS(a_one_src, clock, reset, !(pend_ff && dly_ff), "two result sources")
   `MPV_ASSERT_NEXT(a_start_busy, clock, reset, start, busy, "hash did not start")
   `MPV_ASSERT_ALWAYS(a_stall_res, clock, reset, !rsp_valid || req_stall, "input open with result")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the Merkle path verifier top level.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [63:0] word;
      logic [1:0]  index;
      logic [1:0]  side;
      logic        first;
      logic        last;
   } path_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_digest_word = '0;
   logic [1:0]  req_word_index = '0;
   logic [1:0]  req_side = '0;
   logic        req_first_node = 1'b0;
   logic        req_last_node = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_mismatch;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   merkle_path_verifier_top i_dut (.*);

   always #5 clock = ~clock;

   // Predictor state
   logic [63:0]   root_q [4];
   logic [63:0]   path_digest [4];
   logic [63:0]   sib_words [4];
   logic [1:0]    held_side;
   logic          mismatch_q [$];
   path_word_type word_queue [$];
   int            fail_count = 0;
   int            cycle_count = 0;
   bit            hold_go = 1'b0;
   bit            long_hold = 1'b0;
   bit            stimulus_done = 1'b0;

   task automatic report(input string what);
      $display("ERROR @%0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // SHA-256 of 0x01 || left || right (65-byte message, two blocks)
   function automatic void hash_pair(input logic [255:0] left, input logic [255:0] right,
                                     output logic [255:0] digest);
      logic [1023:0] msg;
      logic [31:0]   h [8];
      logic [31:0]   v [8];
      logic [31:0]   w [64];
      logic [31:0]   t1, t2;
      msg = {8'h01, left, right, 8'h80, 432'd0, 64'd520};
      for (int i = 0; i < 8; i++) h[i] = mpv_pkg::HINIT[255 - 32*i -: 32];
      for (int b = 0; b < 2; b++) begin
         for (int i = 0; i < 16; i++) w[i] = msg[1023 - 512*b - 32*i -: 32];
         for (int i = 16; i < 64; i++)
            w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
         for (int i = 0; i < 8; i++) v[i] = h[i];
         for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + mpv_pkg::KTAB[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) h[i] += v[i];
      end
      digest = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
   endfunction

   // Fold one accepted word into the predicted path state
   task automatic predict_path(input path_word_type t);
      logic [255:0] run, sib, res;
      sib_words[t.index] = t.word;
      if (t.index == 2'd0) held_side = t.side;
      if (t.index != mpv_pkg::LAST_WORD) return;
      run = {path_digest[0], path_digest[1], path_digest[2], path_digest[3]};
      sib = {sib_words[0], sib_words[1], sib_words[2], sib_words[3]};
      if (t.first) res = sib;
      else if (held_side == mpv_pkg::SIDE_RUN_LEFT) hash_pair(run, sib, res);
      else if (held_side == mpv_pkg::SIDE_SIB_LEFT) hash_pair(sib, run, res);
      else res = run;
      for (int i = 0; i < 4; i++) path_digest[i] = res[255 - 64*i -: 64];
      if (t.last) mismatch_q.push_back(res != {root_q[0], root_q[1], root_q[2], root_q[3]});
   endtask

   // Request driver with random gaps
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         predict_path(word_queue.pop_front());
         req_gap = $urandom_range(0, 3);
         if (req_gap == 0 && word_queue.size() > 0) begin
            {req_digest_word, req_word_index, req_side, req_first_node, req_last_node}
               <= word_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (word_queue.size() > 0) begin
            req_valid <= 1'b1;
            {req_digest_word, req_word_index, req_side, req_first_node, req_last_node}
               <= word_queue[0];
         end
      end
   end

   // Long receiver hold, counted on its own
   initial begin
      wait (hold_go);
      long_hold = 1'b1;
      repeat (1500) @(posedge clock);
      long_hold = 1'b0;
   end

   // Response monitor and stall generator
   int rsp_gap = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (mismatch_q.size() == 0) report("result with no expectation");
            else begin
               logic exp_mm;
               exp_mm = mismatch_q.pop_front();
               if (rsp_mismatch !== exp_mm)
                  report($sformatf("mismatch got %b expected %b", rsp_mismatch, exp_mm));
            end
            rsp_gap = $urandom_range(0, 3);
         end
         if (long_hold) begin
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("merkle_path_verifier_top verification failed");
         $finish;
      end
   end

   task automatic write_root(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      root_q[idx] = value;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (word_queue.size() > 0 || req_valid || mismatch_q.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // One full path element, words in order
   task automatic add_element(input logic [63:0] d [4], input logic [1:0] side,
                              input bit first, input bit last);
      path_word_type t;
      for (int i = 0; i < 4; i++) begin
         t.word = d[i]; t.index = 2'(i); t.side = side;
         t.first = (i == 3) ? first : 1'($urandom_range(0, 1));
         t.last  = (i == 3) ? last  : 1'($urandom_range(0, 1));
         word_queue.push_back(t);
      end
   endtask

   task automatic random_element(input bit first, input bit last);
      logic [63:0] d [4];
      for (int i = 0; i < 4; i++) d[i] = rand64();
      add_element(d, 2'($urandom_range(0, 3)), first, last);
   endtask

   // Main stimulus: directed and random proofs; roots set to match sometimes
   initial begin
      logic [63:0] d [4];
      int n;
      for (int i = 0; i < 4; i++) begin
         root_q[i] = '0; path_digest[i] = '0; sib_words[i] = '0;
      end
      held_side = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 4; i++) write_root(2'(i), '0);
      // Directed: zero leaf matches zero root, all-ones leaf, each side code
      for (int i = 0; i < 4; i++) d[i] = '0;
      add_element(d, mpv_pkg::SIDE_RUN_LEFT, 1'b1, 1'b1);
      for (int i = 0; i < 4; i++) d[i] = '1;
      add_element(d, 2'd3, 1'b1, 1'b1);
      add_element(d, mpv_pkg::SIDE_RUN_LEFT, 1'b0, 1'b0);
      add_element(d, mpv_pkg::SIDE_SIB_LEFT, 1'b0, 1'b0);
      add_element(d, 2'd2, 1'b0, 1'b0);
      add_element(d, 2'd3, 1'b0, 1'b1);
      wait_idle();

      // Roots at all ones, then back-pressure while sender keeps offering
      for (int i = 0; i < 4; i++) write_root(2'(i), '1);
      hold_go = 1'b1;
      for (int k = 0; k < 6; k++) random_element(k == 0, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < 4; i++) write_root(2'(i), rand64());
         n = 0;
         while (n < 400) begin
            int len;
            len = $urandom_range(1, 5);
            if ($urandom_range(0, 9) == 0) begin
               // Out-of-order and repeated words
               path_word_type t;
               repeat ($urandom_range(1, 6)) begin
                  t = {rand64(), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))};
                  word_queue.push_back(t);
                  n++;
               end
            end else begin
               for (int k = 0; k < len; k++) random_element(k == 0, k == len - 1);
               n += 4 * len;
            end
         end
         wait_idle();
         // Make the next root match the current path digest
         for (int i = 0; i < 4; i++) write_root(2'(i), path_digest[i]);
         d = path_digest;
         add_element(d, 2'd2, 1'b0, 1'b1);
         wait_idle();
      end

      stimulus_done = 1'b1;
      if (fail_count == 0) begin
         $display("merkle_path_verifier_top verification clean");
      end else begin
         $display("merkle_path_verifier_top verification failed");
      end
      $finish;
   end
endmodule
